[rtl/core/dss_pkg.sv]
// Shared types and codes of the disk seek scheduler.
// Holds the request and result beat structs, command, mode and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

   localparam int CYL_WIDTH   = 12;
   localparam int TOTAL_WIDTH = 20;
   localparam int TABLE_DEPTH_DEFAULT = 16;

   // command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // schedule modes
   localparam logic [2:0] MODE_FCFS  = 3'd0;
   localparam logic [2:0] MODE_SSTF  = 3'd1;
   localparam logic [2:0] MODE_SCAN  = 3'd2;
   localparam logic [2:0] MODE_CSCAN = 3'd3;
   localparam logic [2:0] MODE_LOOK  = 3'd4;
   localparam logic [2:0] MODE_CLOOK = 3'd5;

   // register indexes
   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_MIN  = 2'd1;
   localparam logic [1:0] REG_MAX  = 2'd2;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [CYL_WIDTH-1:0] cylinder;
   } req_beat_type;

   typedef struct packed {
      logic [CYL_WIDTH-1:0]   position;
      logic [TOTAL_WIDTH-1:0] seek_total;
      logic                   last;
   } rsp_beat_type;

endpackage

`default_nettype wire

[rtl/core/disk_seek_scheduler.sv]
// Disk seek scheduler top level: request table, sequencer and shared seek unit.
// Depends on dss_pkg for beat structs and codes.
`timescale 1ns / 1ps
`default_nettype none

// Load and clear beats are taken in the idle state, which they do not leave,
// and register writes are always accepted. A run beat emits the head and then
// the seek sequence; the block stalls its request side until the last result
// sits in the output register. Every step goes through the single registered
// read port of the request table and one shared distance/saturating-add unit.
// FCFS reads and emits each entry in turn. SSTF scans the slots after slot i
// for the nearest entry and swaps it into slot i before emitting it. The sweep
// modes walk the whole table once per emitted position, plus one empty walk per
// sweep direction. The table needs no clearing pass after reset.
module disk_seek_scheduler #(
   parameter int TABLE_DEPTH = dss_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  dss_pkg::req_beat_type    req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output dss_pkg::rsp_beat_type    rsp_data,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [1:0]                csr_index,
   input  wire [dss_pkg::CYL_WIDTH-1:0] csr_data
);
   import dss_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CW    = CYL_WIDTH;
   localparam int TW    = TOTAL_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_F_RD, ST_F_CAP, ST_S_RD, ST_S_CAP, ST_F_EMIT,
      ST_W_RD, ST_W_CAP, ST_W_END, ST_W_MIN, ST_W_TURN, ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [2:0]          mode_ff;
   logic [CW-1:0]       min_ff, max_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CW-1:0]       mem [TABLE_DEPTH];
   logic [CW-1:0]       rdata_ff;
   logic [IDX_W-1:0]    i_ff, j_ff, k_ff;
   logic [CW-1:0]       cur_ff, cur_i_ff, best_d_ff, head_ff, bound_ff, best_ff;
   logic [TW-1:0]       total_ff;
   logic [CW-1:0]       pend_pos_ff;
   logic [TW-1:0]       pend_total_ff;
   logic                phase_ff, found_ff, emitted_min_ff;
   logic                rsp_valid_ff;
   rsp_beat_type        rsp_data_ff;

   logic                out_free, req_acc, emit_fire;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [CW-1:0]       mem_wdata;
   logic [CW-1:0]       dist_b, dist_v, emit_val;
   logic [TW-1:0]       addend;
   logic [TW:0]         sum;
   logic [TW-1:0]       total_in;
   logic                asc, stop_min, cand, better;
   logic [CNT_W-1:0]    i_next, j_next, k_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign asc      = (mode_ff == MODE_SCAN) || (mode_ff == MODE_LOOK);
   assign stop_min = (mode_ff == MODE_SCAN) || (mode_ff == MODE_CSCAN);
   assign i_next   = CNT_W'(i_ff) + CNT_W'(1);
   assign j_next   = CNT_W'(j_ff) + CNT_W'(1);
   assign k_next   = CNT_W'(k_ff) + CNT_W'(1);

   // a result beat is loaded into the output register this cycle
   assign emit_fire = out_free && ((state_ff == ST_F_EMIT) || (state_ff == ST_FINISH) ||
                      (state_ff == ST_W_END && found_ff) ||
                      (state_ff == ST_W_MIN && stop_min && head_ff > min_ff &&
                       !emitted_min_ff));

   // value emitted by the current state
   always_comb begin
      unique case (state_ff)
         ST_F_EMIT: emit_val = cur_i_ff;
         ST_W_MIN:  emit_val = min_ff;
         default:   emit_val = best_ff;
      endcase
   end

   // shared distance and saturating add unit
   assign dist_b = (state_ff == ST_F_CAP || state_ff == ST_S_CAP) ? rdata_ff : emit_val;
   assign dist_v = (cur_ff > dist_b) ? (cur_ff - dist_b) : (dist_b - cur_ff);
   always_comb begin
      if (state_ff == ST_W_TURN) begin
         addend = (max_ff >= min_ff) ? TW'(max_ff - min_ff) : '0;
      end else begin
         addend = TW'(dist_v);
      end
   end
   assign sum      = {1'b0, total_ff} + {1'b0, addend};
   assign total_in = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   // sweep candidate test on the entry just read
   always_comb begin
      if (!phase_ff) begin
         cand   = (rdata_ff < bound_ff) && (rdata_ff >= min_ff);
         better = !found_ff || (rdata_ff > best_ff);
      end else if (asc) begin
         cand   = (rdata_ff > bound_ff) && (rdata_ff <= max_ff);
         better = !found_ff || (rdata_ff < best_ff);
      end else begin
         cand   = (rdata_ff < bound_ff) && (rdata_ff > head_ff);
         better = !found_ff || (rdata_ff > best_ff);
      end
   end

   // table read address and write port
   always_comb begin
      unique case (state_ff)
         ST_S_RD: rd_addr = j_ff;
         ST_W_RD: rd_addr = k_ff;
         default: rd_addr = i_ff;
      endcase
      mem_we    = 1'b0;
      mem_waddr = i_ff;
      mem_wdata = cur_i_ff;
      priority if (state_ff == ST_IDLE) begin
         mem_we    = req_acc && (req_data.cmd == CMD_LOAD) &&
                     (count_ff != CNT_W'(TABLE_DEPTH));
         mem_waddr = count_ff[IDX_W-1:0];
         mem_wdata = req_data.cylinder;
      end else if (state_ff == ST_S_CAP) begin
         mem_we    = (dist_v < best_d_ff);
         mem_waddr = j_ff;
      end else if (state_ff == ST_F_EMIT) begin
         mem_we    = out_free && (mode_ff == MODE_SSTF);
      end
   end

   // request table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FCFS;
         min_ff  <= '0;
         max_ff  <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE: mode_ff <= csr_data[2:0];
            REG_MIN:  min_ff  <= csr_data;
            REG_MAX:  max_ff  <= csr_data;
            default:  ;
         endcase
      end
   end

   // sequencer, running position/total and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         total_ff     <= '0;
      end else begin
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  unique case (req_data.cmd)
                     CMD_LOAD: begin
                        if (count_ff != CNT_W'(TABLE_DEPTH)) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     CMD_CLEAR: count_ff <= '0;
                     CMD_RUN: begin
                        cur_ff         <= req_data.cylinder;
                        head_ff        <= req_data.cylinder;
                        bound_ff       <= req_data.cylinder;
                        total_ff       <= '0;
                        pend_pos_ff    <= req_data.cylinder;
                        pend_total_ff  <= '0;
                        i_ff           <= '0;
                        k_ff           <= '0;
                        phase_ff       <= 1'b0;
                        found_ff       <= 1'b0;
                        emitted_min_ff <= 1'b0;
                        if (mode_ff == MODE_FCFS || mode_ff == MODE_SSTF) begin
                           state_ff <= (count_ff == '0) ? ST_FINISH : ST_F_RD;
                        end else if (mode_ff <= MODE_CLOOK) begin
                           state_ff <= (count_ff == '0) ? ST_W_END : ST_W_RD;
                        end else begin
                           state_ff <= ST_FINISH;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_F_RD: state_ff <= ST_F_CAP;
            ST_F_CAP: begin
               cur_i_ff  <= rdata_ff;
               best_d_ff <= dist_v;
               if (mode_ff == MODE_SSTF && i_next != count_ff) begin
                  j_ff     <= i_next[IDX_W-1:0];
                  state_ff <= ST_S_RD;
               end else begin
                  state_ff <= ST_F_EMIT;
               end
            end
            ST_S_RD: state_ff <= ST_S_CAP;
            ST_S_CAP: begin
               if (dist_v < best_d_ff) begin
                  cur_i_ff  <= rdata_ff;
                  best_d_ff <= dist_v;
               end
               if (j_next == count_ff) begin
                  state_ff <= ST_F_EMIT;
               end else begin
                  j_ff     <= j_next[IDX_W-1:0];
                  state_ff <= ST_S_RD;
               end
            end
            ST_F_EMIT: begin
               if (out_free) begin
                  rsp_data_ff   <= '{pend_pos_ff, pend_total_ff, 1'b0};
                  pend_pos_ff   <= emit_val;
                  pend_total_ff <= total_in;
                  cur_ff        <= emit_val;
                  total_ff      <= total_in;
                  if (i_next == count_ff) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     i_ff     <= i_next[IDX_W-1:0];
                     state_ff <= ST_F_RD;
                  end
               end
            end
            ST_W_RD: state_ff <= ST_W_CAP;
            ST_W_CAP: begin
               if (cand && better) begin
                  best_ff  <= rdata_ff;
                  found_ff <= 1'b1;
               end
               if (k_next == count_ff) begin
                  state_ff <= ST_W_END;
               end else begin
                  k_ff     <= k_next[IDX_W-1:0];
                  state_ff <= ST_W_RD;
               end
            end
            ST_W_END: begin
               if (!found_ff) begin
                  state_ff <= phase_ff ? ST_FINISH : ST_W_MIN;
               end else if (out_free) begin
                  rsp_data_ff   <= '{pend_pos_ff, pend_total_ff, 1'b0};
                  pend_pos_ff   <= emit_val;
                  pend_total_ff <= total_in;
                  cur_ff        <= emit_val;
                  total_ff      <= total_in;
                  bound_ff      <= best_ff;
                  if (!phase_ff && best_ff == min_ff) begin
                     emitted_min_ff <= 1'b1;
                  end
                  found_ff <= 1'b0;
                  k_ff     <= '0;
                  state_ff <= ST_W_RD;
               end
            end
            ST_W_MIN: begin
               // minimum stop for scan and c-scan
               if (stop_min && head_ff > min_ff && !emitted_min_ff) begin
                  if (out_free) begin
                     rsp_data_ff   <= '{pend_pos_ff, pend_total_ff, 1'b0};
                     pend_pos_ff   <= emit_val;
                     pend_total_ff <= total_in;
                     cur_ff        <= emit_val;
                     total_ff      <= total_in;
                     state_ff      <= ST_W_TURN;
                  end
               end else begin
                  state_ff <= ST_W_TURN;
               end
            end
            ST_W_TURN: begin
               // c-scan jumps to the upper limit without a result
               if (mode_ff == MODE_CSCAN) begin
                  total_ff <= total_in;
                  cur_ff   <= max_ff;
               end
               phase_ff <= 1'b1;
               found_ff <= 1'b0;
               k_ff     <= '0;
               bound_ff <= asc ? head_ff : max_ff;
               state_ff <= (count_ff == '0) ? ST_FINISH : ST_W_RD;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_data_ff  <= '{pend_pos_ff, pend_total_ff, 1'b1};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // table fill never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("request count beyond table depth");

   // last beat leaves the sequencer idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("finish did not load last beat");

   // running total never falls within a run
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && $past(state_ff) != ST_IDLE) |-> total_ff >= $past(total_ff))
      else $error("seek total decreased");

endmodule

`default_nettype wire

[bench/disk_seek_scheduler_tb.sv]
// Self-checking testbench for the disk seek scheduler.
// Depends on dss_pkg and disk_seek_scheduler; a scoreboard class predicts each run.
`timescale 1ns / 1ps

module disk_seek_scheduler_tb;
   import dss_pkg::*;

   localparam int DEPTH       = TABLE_DEPTH_DEFAULT;
   localparam int TOTAL_SAT   = (1 << TOTAL_WIDTH) - 1;
   localparam int QUIET_LIMIT = 20000;

   // predicts seek sequences and checks result beats in order
   class seek_scoreboard;
      rsp_beat_type         pending_seeks[$];
      logic [CYL_WIDTH-1:0] table_q [DEPTH];
      int unsigned          entry_count;
      int unsigned          head_pos;
      int unsigned          seek_sum;
      logic [2:0]           mode;
      int unsigned          lo_cyl;
      int unsigned          hi_cyl;
      int                   errors;

      function new();
         entry_count = 0;
         mode        = MODE_FCFS;
         lo_cyl      = 0;
         hi_cyl      = (1 << CYL_WIDTH) - 1;
         errors      = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CYL_WIDTH-1:0] value);
         case (idx)
            REG_MODE: mode = value[2:0];
            REG_MIN:  lo_cyl = value;
            REG_MAX:  hi_cyl = value;
            default: ;
         endcase
      endfunction

      function int unsigned gap(int unsigned a, int unsigned b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void add_seek(int unsigned d);
         seek_sum = seek_sum + d;
         if (seek_sum > TOTAL_SAT) seek_sum = TOTAL_SAT;
      endfunction

      function void visit(int unsigned cyl);
         rsp_beat_type e;
         add_seek(gap(head_pos, cyl));
         head_pos     = cyl;
         e.position   = cyl[CYL_WIDTH-1:0];
         e.seek_total = seek_sum[TOTAL_WIDTH-1:0];
         e.last       = 1'b0;
         pending_seeks.push_back(e);
      endfunction

      // greedy nearest-first, swapping in place as it goes
      function void sstf_reorder(int unsigned start);
         int unsigned pt, best, d;
         logic [CYL_WIDTH-1:0] t;
         pt = start;
         for (int i = 0; i < entry_count; i++) begin
            best = gap(pt, table_q[i]);
            for (int j = i + 1; j < entry_count; j++) begin
               d = gap(pt, table_q[j]);
               if (d < best) begin
                  best       = d;
                  t          = table_q[j];
                  table_q[j] = table_q[i];
                  table_q[i] = t;
               end
            end
            pt = table_q[i];
         end
      endfunction

      function void sweep(int unsigned start);
         int unsigned srt [$];
         int unsigned v;
         bit dup, min_seen, stop;
         int p;
         // sorted distinct copy of the live entries
         for (int i = 0; i < entry_count; i++) begin
            v   = table_q[i];
            dup = 0;
            foreach (srt[k]) if (srt[k] == v) dup = 1;
            if (!dup) begin
               p = 0;
               while (p < srt.size() && srt[p] < v) p++;
               srt.insert(p, v);
            end
         end
         stop     = (mode == MODE_SCAN) || (mode == MODE_CSCAN);
         min_seen = 0;
         for (int k = srt.size() - 1; k >= 0; k--)
            if (srt[k] < start && srt[k] >= lo_cyl) begin
               visit(srt[k]);
               if (srt[k] == lo_cyl) min_seen = 1;
            end
         if (stop && start > lo_cyl && !min_seen) visit(lo_cyl);
         if (mode == MODE_SCAN || mode == MODE_LOOK) begin
            for (int k = 0; k < srt.size(); k++)
               if (srt[k] > start && srt[k] <= hi_cyl) visit(srt[k]);
         end else begin
            // wrap to the top without reporting it
            if (mode == MODE_CSCAN) begin
               if (hi_cyl >= lo_cyl) add_seek(hi_cyl - lo_cyl);
               head_pos = hi_cyl;
            end
            for (int k = srt.size() - 1; k >= 0; k--)
               if (srt[k] > start && srt[k] < hi_cyl) visit(srt[k]);
         end
      endfunction

      function void note_request(req_beat_type b);
         rsp_beat_type e;
         case (b.cmd)
            CMD_LOAD: begin
               if (entry_count < DEPTH) begin
                  table_q[entry_count] = b.cylinder;
                  entry_count++;
               end
            end
            CMD_CLEAR: entry_count = 0;
            CMD_RUN: begin
               head_pos = b.cylinder;
               seek_sum = 0;
               visit(b.cylinder);
               if (mode == MODE_FCFS || mode == MODE_SSTF) begin
                  if (mode == MODE_SSTF) sstf_reorder(b.cylinder);
                  for (int i = 0; i < entry_count; i++) visit(table_q[i]);
               end else if (mode <= MODE_CLOOK) begin
                  sweep(b.cylinder);
               end
               e      = pending_seeks.pop_back();
               e.last = 1'b1;
               pending_seeks.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type e;
         if (pending_seeks.size() == 0) begin
            $error("unexpected result beat: position %0d", got.position);
            errors++;
            return;
         end
         e = pending_seeks.pop_front();
         if (got.position !== e.position) begin
            $error("position: expected %0d, got %0d", e.position, got.position);
            errors++;
         end
         if (got.seek_total !== e.seek_total) begin
            $error("seek_total: expected %0d, got %0d", e.seek_total, got.seek_total);
            errors++;
         end
         if (got.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_beat_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_beat_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = '0;
   logic [CYL_WIDTH-1:0] csr_data  = '0;

   seek_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_rsp      = 0;
   int  quiet_cycles  = 0;
   logic [CYL_WIDTH-1:0] recent [$];

   disk_seek_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_req(logic [1:0] cmd, logic [CYL_WIDTH-1:0] cyl);
      req_beat_type b;
      b.cmd      = cmd;
      b.cylinder = cyl;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      sb.note_request(b);
      if (cmd == CMD_LOAD) recent.push_back(cyl);
      if (recent.size() > 24) void'(recent.pop_front());
   endtask

   // stop sending and wait until every expected result is in
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_seeks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CYL_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CYL_WIDTH-1:0] pick_cyl();
      int k;
      k = $urandom_range(0, 9);
      if (k < 2 && recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
      if (k == 2) return CYL_WIDTH'(sb.lo_cyl);
      if (k == 3) return CYL_WIDTH'(sb.hi_cyl);
      if (k == 4) return CYL_WIDTH'(sb.lo_cyl + $urandom_range(0, 8));
      if (k == 5) return CYL_WIDTH'(sb.hi_cyl - $urandom_range(0, 8));
      return CYL_WIDTH'($urandom_range(0, (1 << CYL_WIDTH) - 1));
   endfunction

   // mostly clear / load / run sequences, with some stray beats mixed in
   task automatic random_phase(int beats);
      int sent, nloads;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 99) < 10) begin
            send_req(2'($urandom_range(0, 3)),
                     CYL_WIDTH'($urandom_range(0, (1 << CYL_WIDTH) - 1)));
            sent++;
         end else begin
            if ($urandom_range(0, 99) < 75) begin
               send_req(CMD_CLEAR, CYL_WIDTH'($urandom_range(0, (1 << CYL_WIDTH) - 1)));
               sent++;
            end
            nloads = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(0, 6);
            repeat (nloads) send_req(CMD_LOAD, pick_cyl());
            send_req(CMD_RUN, pick_cyl());
            sent += nloads + 1;
         end
      end
   endtask

   initial begin
      int lo, hi;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, full table, stray command
      send_req(CMD_RUN, 12'd0);
      send_req(CMD_RUN, 12'hfff);
      send_req(CMD_LOAD, 12'd0);
      send_req(CMD_LOAD, 12'hfff);
      send_req(CMD_LOAD, 12'h555);
      send_req(CMD_LOAD, 12'haaa);
      send_req(CMD_LOAD, 12'h555);
      send_req(CMD_RUN, 12'h800);
      send_req(2'd3, 12'h123);
      send_req(CMD_RUN, 12'hfff);
      send_req(CMD_CLEAR, 12'd0);
      for (int i = 0; i < 17; i++) begin
         if (i < 12) send_req(CMD_LOAD, 12'(i * 341));
      end
      drain();
      write_reg(REG_MODE, CYL_WIDTH'(MODE_SSTF));
      for (int i = 0; i < 5; i++) send_req(CMD_LOAD, 12'(4095 - i * 97));
      send_req(CMD_LOAD, 12'd7);
      send_req(CMD_RUN, 12'h7ff);
      send_req(CMD_RUN, 12'd0);
      drain();

      // random phases over modes, limits and idle patterns
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: begin lo = 0; hi = 4095; end
            1: begin lo = $urandom_range(0, 2000); hi = $urandom_range(lo, 4095); end
            2: begin lo = $urandom_range(2048, 4095); hi = $urandom_range(0, lo); end
            default: begin lo = $urandom_range(0, 4095); hi = lo; end
         endcase
         write_reg(REG_MODE, CYL_WIDTH'(p % 6));
         write_reg(REG_MIN, 12'(lo));
         write_reg(REG_MAX, 12'(hi));
         case ((p / 2) % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         // long receiver hold-off so the block backs up into its input
         if (p == 1) begin
            fork
               begin
                  hold_rsp = 1;
                  repeat (400) @(negedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         random_phase(22);
         drain();
      end

      if (sb.errors == 0 && sb.pending_seeks.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/dss_pkg.sv
rtl/core/disk_seek_scheduler.sv
bench/disk_seek_scheduler_tb.sv
